// ----- hdl/rc6_pkg.sv -----
package rc6_pkg;

    localparam logic [31:0] P32 = 32'hB7E15163;
    localparam logic [31:0] Q32 = 32'h9E3779B9;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W3   = 3'd4;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;

    localparam logic CMD_ENCRYPT = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_MRD,
        S_MWR,
        S_CRD,
        S_CRUN,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_ENC_PRE,
        OP_ENC_ROUND,
        OP_ENC_POST,
        OP_DEC_PRE,
        OP_DEC_ROUND,
        OP_DEC_POST
    } t_op;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} << n;
        return w[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} >> n;
        return w[31:0];
    endfunction

    function automatic logic [31:0] fquad(input logic [31:0] x);
        logic [31:0] p;
        p = x * {x[30:0], 1'b1};
        return rotl32(p, 5'd5);
    endfunction

endpackage

// ----- hdl/rc6_if.sv -----
interface rc6_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] block_low;
    logic [63:0] block_high;
    modport source (output valid, cmd, block_low, block_high, input ready);
    modport sink   (input valid, cmd, block_low, block_high, output ready);
endinterface

interface rc6_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;
    modport source (output valid, result_low, result_high, input ready);
    modport sink   (input valid, result_low, result_high, output ready);
endinterface

interface rc6_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rc6_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/rc6_ram.sv -----
module rc6_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 22
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/rc6_round.sv -----
module rc6_round (
    input  rc6_pkg::t_op i_op,
    input  logic [31:0]  i_a,
    input  logic [31:0]  i_b,
    input  logic [31:0]  i_c,
    input  logic [31:0]  i_d,
    input  logic [31:0]  i_k0,
    input  logic [31:0]  i_k1,
    output logic [31:0]  o_a,
    output logic [31:0]  o_b,
    output logic [31:0]  o_c,
    output logic [31:0]  o_d
);

    logic        w_dec;
    logic [31:0] w_fx;
    logic [31:0] w_fy;

    assign w_dec = (i_op == rc6_pkg::OP_DEC_ROUND);
    assign w_fx  = rc6_pkg::fquad(w_dec ? i_a : i_b);
    assign w_fy  = rc6_pkg::fquad(w_dec ? i_c : i_d);

    always_comb begin
        o_a = i_a;
        o_b = i_b;
        o_c = i_c;
        o_d = i_d;
        case (i_op)
            rc6_pkg::OP_ENC_PRE: begin
                o_b = i_b + i_k0;
                o_d = i_d + i_k1;
            end
            rc6_pkg::OP_ENC_ROUND: begin
                o_a = i_b;
                o_b = rc6_pkg::rotl32(i_c ^ w_fy, w_fx[4:0]) + i_k1;
                o_c = i_d;
                o_d = rc6_pkg::rotl32(i_a ^ w_fx, w_fy[4:0]) + i_k0;
            end
            rc6_pkg::OP_ENC_POST: begin
                o_a = i_a + i_k0;
                o_c = i_c + i_k1;
            end
            rc6_pkg::OP_DEC_PRE: begin
                o_a = i_a - i_k0;
                o_c = i_c - i_k1;
            end
            rc6_pkg::OP_DEC_ROUND: begin
                o_a = rc6_pkg::rotr32(i_d - i_k0, w_fy[4:0]) ^ w_fx;
                o_b = i_a;
                o_c = rc6_pkg::rotr32(i_b - i_k1, w_fx[4:0]) ^ w_fy;
                o_d = i_c;
            end
            rc6_pkg::OP_DEC_POST: begin
                o_b = i_b - i_k0;
                o_d = i_d - i_k1;
            end
            default: begin
                o_a = i_a;
            end
        endcase
    end

endmodule

// ----- hdl/rc6_block_cipher_core.sv -----
// Channel   Dir  Modport  Payload
// i_blk     in   sink     cmd, block_low, block_high
// o_res     out  source   result_low, result_high
// i_cfg     in   sink     index, data (always ready)
//
// One shared round unit runs one round per cycle on round-key pairs read from
// a RAM port. After a key change the first block seeds the key RAM, then mixes
// the key in (each mixing step a read then a write of the key RAM).
// Reset is synchronous and active low; the round keys are rebuilt for the
// first block after it. A result waiting on o_res holds; a new block is taken
// meanwhile, but its own result waits until o_res is free.
module rc6_block_cipher_core #(
    parameter int ROUNDS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rc6_in_if.sink    i_blk,
    rc6_out_if.source o_res,
    rc6_cfg_if.sink   i_cfg
);

    localparam int RK     = 2 * ROUNDS + 4;
    localparam int NPAIR  = ROUNDS + 2;
    localparam int PA_W   = $clog2(NPAIR);
    localparam int RK_W   = $clog2(RK);
    localparam int MAXC   = (RK > 8) ? RK : 8;
    localparam int STEP_W = $clog2(3 * MAXC + 1);

    rc6_pkg::t_state r_state;
    rc6_pkg::t_state n_state;

    logic [1:0]        r_size;
    logic [63:0]       r_key [4];
    logic              r_keys_ready;
    logic [31:0]       r_lw [8];
    logic              r_dec;
    logic [31:0]       r_a, r_b, r_c, r_d;
    logic [31:0]       r_ka, r_kb;
    logic [31:0]       r_seed;
    logic [PA_W-1:0]   r_k;
    logic [RK_W-1:0]   r_i;
    logic [2:0]        r_j;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [63:0]       r_out_low, r_out_high;

    logic [3:0]        w_cw;
    logic [STEP_W-1:0] w_steps;
    logic              w_ram_we;
    logic [PA_W-1:0]   w_waddr;
    logic [63:0]       w_wdata;
    logic [PA_W-1:0]   w_raddr;
    logic [63:0]       w_rdata;
    logic [31:0]       w_word;
    logic [31:0]       w_sa;
    logic [31:0]       w_sab;
    logic [31:0]       w_sb;
    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_seed_last;
    logic              w_mix_last;
    logic              w_crun_last;
    logic [PA_W-1:0]   w_k_first;
    logic [PA_W-1:0]   w_k_next;
    rc6_pkg::t_op      w_op;
    logic [31:0]       w_ra, w_rb, w_rc, w_rd;

    always_comb begin
        case (r_size)
            rc6_pkg::KEY_128: w_cw = 4'd4;
            rc6_pkg::KEY_192: w_cw = 4'd6;
            default:          w_cw = 4'd8;
        endcase
    end

    assign w_steps = (RK > 8) ? STEP_W'(3 * RK) : STEP_W'(3 * {28'd0, w_cw} > 3 * RK ?
                     3 * {28'd0, w_cw} : 3 * RK);

    assign w_in_xfer   = i_blk.valid && i_blk.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_seed_last = (r_k == PA_W'(NPAIR - 1));
    assign w_mix_last  = (r_step == w_steps - STEP_W'(1));
    assign w_k_first   = r_dec ? PA_W'(NPAIR - 1) : '0;
    assign w_crun_last = r_dec ? (r_k == '0) : (r_k == PA_W'(NPAIR - 1));
    assign w_k_next    = r_dec ? (r_k - PA_W'(1)) : (r_k + PA_W'(1));

    assign w_word = r_i[0] ? w_rdata[63:32] : w_rdata[31:0];
    assign w_sa   = rc6_pkg::rotl32(w_word + r_ka + r_kb, 5'd3);
    assign w_sab  = w_sa + r_kb;
    assign w_sb   = rc6_pkg::rotl32(r_lw[r_j] + w_sab, w_sab[4:0]);

    always_comb begin
        if (r_k == w_k_first) begin
            w_op = r_dec ? rc6_pkg::OP_DEC_PRE : rc6_pkg::OP_ENC_PRE;
        end else if (w_crun_last) begin
            w_op = r_dec ? rc6_pkg::OP_DEC_POST : rc6_pkg::OP_ENC_POST;
        end else begin
            w_op = r_dec ? rc6_pkg::OP_DEC_ROUND : rc6_pkg::OP_ENC_ROUND;
        end
    end

    rc6_round u_round (
        .i_op (w_op),
        .i_a  (r_a),
        .i_b  (r_b),
        .i_c  (r_c),
        .i_d  (r_d),
        .i_k0 (w_rdata[31:0]),
        .i_k1 (w_rdata[63:32]),
        .o_a  (w_ra),
        .o_b  (w_rb),
        .o_c  (w_rc),
        .o_d  (w_rd)
    );

    rc6_ram #(
        .WIDTH (64),
        .DEPTH (NPAIR)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            rc6_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = r_keys_ready ? rc6_pkg::S_CRD : rc6_pkg::S_SEED;
                end
            end
            rc6_pkg::S_SEED: begin
                if (w_seed_last) begin
                    n_state = rc6_pkg::S_MRD;
                end
            end
            rc6_pkg::S_MRD: n_state = rc6_pkg::S_MWR;
            rc6_pkg::S_MWR: n_state = w_mix_last ? rc6_pkg::S_CRD : rc6_pkg::S_MRD;
            rc6_pkg::S_CRD: n_state = rc6_pkg::S_CRUN;
            rc6_pkg::S_CRUN: begin
                if (w_crun_last) begin
                    n_state = rc6_pkg::S_OUT;
                end
            end
            rc6_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = rc6_pkg::S_IDLE;
                end
            end
            default: n_state = rc6_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_ram_we = 1'b0;
        w_waddr  = r_k;
        w_wdata  = {r_seed + rc6_pkg::Q32, r_seed};
        w_raddr  = r_k;
        case (r_state)
            rc6_pkg::S_SEED: begin
                w_ram_we = 1'b1;
            end
            rc6_pkg::S_MRD: begin
                w_raddr = r_i[RK_W-1:1];
            end
            rc6_pkg::S_MWR: begin
                w_ram_we = 1'b1;
                w_waddr  = r_i[RK_W-1:1];
                w_wdata  = r_i[0] ? {w_sa, w_rdata[31:0]} : {w_rdata[63:32], w_sa};
            end
            rc6_pkg::S_CRD: begin
                w_raddr = w_k_first;
            end
            rc6_pkg::S_CRUN: begin
                w_raddr = w_k_next;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    assign i_blk.ready       = (r_state == rc6_pkg::S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = r_out_valid;
    assign o_res.result_low  = r_out_low;
    assign o_res.result_high = r_out_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rc6_pkg::S_IDLE;
            r_size       <= rc6_pkg::KEY_128;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int n = 0; n < 4; n++) begin
                r_key[n] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == rc6_pkg::CFG_KEY_SIZE) begin
                    r_size       <= i_cfg.data[1:0];
                    r_keys_ready <= 1'b0;
                end else if (i_cfg.index >= rc6_pkg::CFG_KEY_W0 &&
                             i_cfg.index <= rc6_pkg::CFG_KEY_W3) begin
                    r_key[2'(i_cfg.index - rc6_pkg::CFG_KEY_W0)] <= i_cfg.data;
                    r_keys_ready <= 1'b0;
                end
            end

            if (r_state == rc6_pkg::S_MWR && w_mix_last) begin
                r_keys_ready <= 1'b1;
            end

            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == rc6_pkg::S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rc6_pkg::S_IDLE: begin
                r_dec  <= (i_blk.cmd != rc6_pkg::CMD_ENCRYPT);
                r_a    <= i_blk.block_low[31:0];
                r_b    <= i_blk.block_low[63:32];
                r_c    <= i_blk.block_high[31:0];
                r_d    <= i_blk.block_high[63:32];
                r_k    <= '0;
                r_i    <= '0;
                r_j    <= '0;
                r_step <= '0;
                r_ka   <= '0;
                r_kb   <= '0;
                r_seed <= rc6_pkg::P32;
                for (int n = 0; n < 8; n++) begin
                    r_lw[n] <= (n < 32'(w_cw)) ? r_key[n / 2][(n % 2) * 32 +: 32] : '0;
                end
            end
            rc6_pkg::S_SEED: begin
                r_seed <= r_seed + rc6_pkg::Q32 + rc6_pkg::Q32;
                r_k    <= r_k + PA_W'(1);
            end
            rc6_pkg::S_MWR: begin
                r_ka     <= w_sa;
                r_kb     <= w_sb;
                r_lw[r_j] <= w_sb;
                r_i      <= (r_i == RK_W'(RK - 1)) ? '0 : r_i + RK_W'(1);
                r_j      <= ({1'b0, r_j} == w_cw - 4'd1) ? '0 : r_j + 3'd1;
                r_step   <= r_step + STEP_W'(1);
            end
            rc6_pkg::S_CRD: begin
                r_k <= w_k_first;
            end
            rc6_pkg::S_CRUN: begin
                r_a <= w_ra;
                r_b <= w_rb;
                r_c <= w_rc;
                r_d <= w_rd;
                r_k <= w_k_next;
            end
            rc6_pkg::S_OUT: begin
                if (w_out_free) begin
                    r_out_low  <= {r_b, r_a};
                    r_out_high <= {r_d, r_c};
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    a_crypt_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc6_pkg::S_CRUN) |-> r_keys_ready)
        else $error("cipher rounds running on stale round keys");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == rc6_pkg::S_OUT))
        else $error("result raised outside the output state");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_blk.valid && i_blk.ready) |=> (r_state != rc6_pkg::S_IDLE))
        else $error("block transfer did not start work");

    a_mix_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc6_pkg::S_MWR) |-> ({1'b0, r_j} < w_cw))
        else $error("key mix index beyond key length");

endmodule

// ----- tb/sv/rc6_block_cipher_core_tb.sv -----
`timescale 1ns / 100ps

module rc6_block_cipher_core_tb;

    localparam int ROUNDS   = 20;
    localparam int RK_N     = 2 * ROUNDS + 4;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        logic [63:0] res_low;
        logic [63:0] res_high;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rc6_in_if  blk_if ();
    rc6_out_if res_if ();
    rc6_cfg_if cfg_if ();

    rc6_block_cipher_core #(.ROUNDS(ROUNDS)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_blk  (blk_if.sink),
        .o_res  (res_if.source),
        .i_cfg  (cfg_if.sink)
    );

    always #5 i_clk = ~i_clk;

    logic [1:0]  key_size;
    logic [63:0] key_regs [4];
    logic [31:0] round_keys [RK_N];
    bit          keys_fresh;

    t_result     pending_results [$];
    int          fail_cnt;
    int          blocks_sent;
    int          results_seen;
    int          idle_cycles;
    bit          gaps_on;
    bit          hold_off;
    int          hold_cycles;

    function automatic logic [31:0] rol(logic [31:0] x, logic [4:0] n);
        return (x << n) | (x >> (6'd32 - n));
    endfunction

    function automatic logic [31:0] ror(logic [31:0] x, logic [4:0] n);
        return (x >> n) | (x << (6'd32 - n));
    endfunction

    function automatic logic [31:0] quad_mix(logic [31:0] x);
        logic [31:0] p;
        p = x * (2 * x + 32'd1);
        return rol(p, 5'd5);
    endfunction

    task automatic expand_key_schedule();
        logic [31:0] lw [8];
        logic [31:0] a;
        logic [31:0] b;
        int          nwords;
        int          steps;
        int          i;
        int          j;
        nwords = (key_size == rc6_pkg::KEY_128) ? 4 :
                 (key_size == rc6_pkg::KEY_192) ? 6 : 8;
        for (int k = 0; k < 8; k++)
            lw[k] = (k < nwords) ? key_regs[k >> 1][(k & 1) * 32 +: 32] : 32'd0;
        round_keys[0] = rc6_pkg::P32;
        for (int k = 1; k < RK_N; k++)
            round_keys[k] = round_keys[k - 1] + rc6_pkg::Q32;
        a = 0;
        b = 0;
        i = 0;
        j = 0;
        steps = 3 * ((nwords > RK_N) ? nwords : RK_N);
        for (int s = 0; s < steps; s++) begin
            a = rol(round_keys[i] + a + b, 5'd3);
            round_keys[i] = a;
            b = rol(lw[j] + a + b, 5'(a + b));
            lw[j] = b;
            i = (i + 1) % RK_N;
            j = (j + 1) % nwords;
        end
        keys_fresh = 1'b1;
    endtask

    task automatic predict_block(logic op, logic [63:0] lo, logic [63:0] hi);
        logic [31:0] a, b, c, d, t, u, tmp;
        t_result     r;
        if (!keys_fresh)
            expand_key_schedule();
        a = lo[31:0];
        b = lo[63:32];
        c = hi[31:0];
        d = hi[63:32];
        if (op == rc6_pkg::CMD_ENCRYPT) begin
            b += round_keys[0];
            d += round_keys[1];
            for (int n = 1; n <= ROUNDS; n++) begin
                t = quad_mix(b);
                u = quad_mix(d);
                a = rol(a ^ t, u[4:0]) + round_keys[2 * n];
                c = rol(c ^ u, t[4:0]) + round_keys[2 * n + 1];
                tmp = a; a = b; b = c; c = d; d = tmp;
            end
            a += round_keys[2 * ROUNDS + 2];
            c += round_keys[2 * ROUNDS + 3];
        end else begin
            c -= round_keys[2 * ROUNDS + 3];
            a -= round_keys[2 * ROUNDS + 2];
            for (int n = ROUNDS; n >= 1; n--) begin
                tmp = d; d = c; c = b; b = a; a = tmp;
                u = quad_mix(d);
                t = quad_mix(b);
                c = ror(c - round_keys[2 * n + 1], t[4:0]) ^ u;
                a = ror(a - round_keys[2 * n], u[4:0]) ^ t;
            end
            d -= round_keys[1];
            b -= round_keys[0];
        end
        r.res_low  = {b, a};
        r.res_high = {d, c};
        pending_results.push_back(r);
    endtask

    task automatic gap(int pct);
        if (gaps_on && $urandom_range(99) < pct)
            repeat ($urandom_range(14, 1)) @(negedge i_clk);
    endtask

    task automatic send_block(logic op, logic [63:0] lo, logic [63:0] hi);
        gap(20);
        blk_if.valid      <= 1'b1;
        blk_if.cmd        <= op;
        blk_if.block_low  <= lo;
        blk_if.block_high <= hi;
        do @(posedge i_clk); while (!blk_if.ready);
        predict_block(op, lo, hi);
        blocks_sent++;
        @(negedge i_clk);
        blk_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [rc6_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == rc6_pkg::CFG_KEY_SIZE) begin
            key_size   = val[1:0];
            keys_fresh = 1'b0;
        end else if (idx <= rc6_pkg::CFG_KEY_W3) begin
            key_regs[idx - rc6_pkg::CFG_KEY_W0] = val;
            keys_fresh = 1'b0;
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (ROUNDS + 8) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] edge_word(int sel);
        case (sel)
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0001;
            default: return rand64();
        endcase
    endfunction

    task automatic load_key(logic [1:0] size, logic [63:0] k0, logic [63:0] k1,
                            logic [63:0] k2, logic [63:0] k3);
        drain();
        write_reg(rc6_pkg::CFG_KEY_SIZE, {62'd0, size});
        write_reg(rc6_pkg::CFG_KEY_W0, k0);
        write_reg(rc6_pkg::CFG_KEY_W0 + 3'd1, k1);
        write_reg(rc6_pkg::CFG_KEY_W0 + 3'd2, k2);
        write_reg(rc6_pkg::CFG_KEY_W3, k3);
    endtask

    task automatic test_default_key();
        send_block(rc6_pkg::CMD_ENCRYPT, 64'd0, 64'd0);
        send_block(~rc6_pkg::CMD_ENCRYPT, 64'd0, 64'd0);
        send_block(rc6_pkg::CMD_ENCRYPT, '1, '1);
        send_block(~rc6_pkg::CMD_ENCRYPT, '1, '1);
    endtask

    task automatic test_directed_keys();
        for (int s = 0; s < 4; s++) begin
            load_key(s[1:0], edge_word(s), edge_word(s + 1), rand64(), rand64());
            for (int v = 0; v < 4; v++)
                send_block(v[0], edge_word(v), edge_word(3 - v));
        end
        drain();
        write_reg(rc6_pkg::CFG_KEY_W3 + 3'd1, rand64());
        write_reg(rc6_pkg::CFG_KEY_W3 + 3'd3, '1);
        send_block(rc6_pkg::CMD_ENCRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    endtask

    task automatic test_random_blocks(int count, int size_sel);
        load_key(size_sel < 0 ? 2'($urandom_range(3)) : 2'(size_sel),
                 rand64(), rand64(), rand64(), rand64());
        repeat (count)
            send_block(1'($urandom_range(1)), rand64(), rand64());
    endtask

    task automatic test_backpressure();
        drain();
        hold_off = 1'b1;
        repeat (12)
            send_block(1'($urandom_range(1)), rand64(), rand64());
    endtask

    always @(negedge i_clk) begin
        if (hold_off) begin
            hold_off     <= 1'b0;
            res_if.ready <= 1'b0;
            hold_cycles  <= 300;
        end else if (hold_cycles > 0) begin
            res_if.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else if (gaps_on && res_if.ready && $urandom_range(99) < 8) begin
            res_if.ready <= 1'b0;
            hold_cycles  <= $urandom_range(13, 0);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result %h %h", res_if.result_low, res_if.result_high);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.result_low !== want.res_low) begin
                    $error("result_low exp %h got %h", want.res_low, res_if.result_low);
                    fail_cnt++;
                end
                if (res_if.result_high !== want.res_high) begin
                    $error("result_high exp %h got %h", want.res_high, res_if.result_high);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((blk_if.valid && blk_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired, %0d results outstanding",
                     pending_results.size());
            $display("rc6_block_cipher_core regression: fail");
            $finish;
        end
    end

    initial begin
        blk_if.valid      = 1'b0;
        blk_if.cmd        = 1'b0;
        blk_if.block_low  = '0;
        blk_if.block_high = '0;
        res_if.ready      = 1'b1;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        key_size          = rc6_pkg::KEY_128;
        key_regs          = '{default: '0};
        keys_fresh        = 1'b0;
        fail_cnt          = 0;
        blocks_sent       = 0;
        results_seen      = 0;
        idle_cycles       = 0;
        gaps_on           = 1'b1;
        hold_off          = 1'b0;
        hold_cycles       = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_key();
        test_directed_keys();
        test_backpressure();
        for (int p = 0; p < 12; p++)
            test_random_blocks(100, p % 4);
        gaps_on = 1'b0;
        test_random_blocks(150, -1);
        drain();

        $display("%0d blocks sent, %0d results checked over all key sizes,",
                 blocks_sent, results_seen);
        $display("both directions, random gaps and a long output stall");
        if (fail_cnt == 0 && pending_results.size() == 0)
            $display("rc6_block_cipher_core regression: pass");
        else
            $display("rc6_block_cipher_core regression: fail");
        $finish;
    end
endmodule

// ----- rc6_block_cipher_core.f -----
hdl/rc6_pkg.sv
hdl/rc6_if.sv
hdl/rc6_ram.sv
hdl/rc6_round.sv
hdl/rc6_block_cipher_core.sv
tb/sv/rc6_block_cipher_core_tb.sv
